>>> rtl/core/assert_macros.svh
// shared assertion macros, clocked on clk and masked while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

>>> rtl/core/gsdp_pkg.sv
// ----------------------------------------------------------------------------
// gsdp_pkg
// Shared widths, codes and types of the ground sector direction picker.
// ----------------------------------------------------------------------------
`default_nettype none

package gsdp_pkg;

  localparam int COL_W       = 10;
  localparam int ROW_W       = 10;
  localparam int PIX_W       = 8;
  localparam int FH_W        = 11;
  localparam int DIR_W       = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 11;
  localparam int CNT_W       = 12;
  localparam int PCT_W       = 7;
  localparam int SQ_W        = 20;
  localparam int TY_W        = 22;
  localparam int DIVD_W      = 19;
  localparam int SECTORS     = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;
  localparam int QUEUE_CNT_W = 3;

  localparam int PERCENT_SCALE     = 100;
  localparam int THRESHOLD_PERCENT = 90;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LUMA_MIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LUMA_MAX     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CB_MIN       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CB_MAX       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CR_MIN       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CR_MAX       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd6;

  // sector / direction codes
  localparam logic [DIR_W-1:0] SECTOR_FIRST  = 2'd0;
  localparam logic [DIR_W-1:0] SECTOR_MIDDLE = 2'd1;
  localparam logic [DIR_W-1:0] SECTOR_LAST   = 2'd2;

  typedef struct packed {
    logic [PIX_W-1:0] luma_min;
    logic [PIX_W-1:0] luma_max;
    logic [PIX_W-1:0] cb_min;
    logic [PIX_W-1:0] cb_max;
    logic [PIX_W-1:0] cr_min;
    logic [PIX_W-1:0] cr_max;
    logic [FH_W-1:0]  frame_height;
  } gsdp_cfg_t;

  // classified pixel handed from front to back
  typedef struct packed {
    logic             region;
    logic             ground;
    logic [DIR_W-1:0] sector;
    logic             last;
  } gsdp_item_t;

endpackage

`default_nettype wire

>>> rtl/core/ground_sector_direction_picker.sv
// ----------------------------------------------------------------------------
// ground_sector_direction_picker
// Per-frame ground direction from a YCbCr pixel stream with coordinates.
// ----------------------------------------------------------------------------
// A pixel stream goes in, one direction per frame comes out. Ordinary pixels
// are taken one per cycle while the queue has room: the front squares the
// column and row offset and sorts each region pixel into its sector in two
// pipelined steps, then a four-item queue hands it to the back, which counts
// it. After counting a pixel with in_frame_end set, the back runs three
// divisions, each one load plus seven restoring steps on a single shared
// compare-subtract, then a history update and a decision. Pixels arriving
// meanwhile fill the queue and then stall the input, so frame ends belong in
// blanking. The direction sits in an output register, and counting of the
// next frame goes on while it waits to be taken; only a second frame end
// blocks behind an untaken direction. Configuration is written through
// cfg_wr_en/cfg_index/cfg_data; the user must write it only while no item is
// in flight, which the block does not enforce; there is no read-back.
`default_nettype none

module ground_sector_direction_picker #(
  parameter int ROI_WIDTH       = 30,
  parameter int ROI_HALF_HEIGHT = 40,
  parameter int HISTORY_DEPTH   = 3
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // configuration write port
  input  wire logic                             cfg_wr_en,
  input  wire logic [gsdp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [gsdp_pkg::CFG_DATA_W-1:0]  cfg_data,
  // pixel channel
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [gsdp_pkg::COL_W-1:0]       in_column,
  input  wire logic [gsdp_pkg::ROW_W-1:0]       in_row,
  input  wire logic [gsdp_pkg::PIX_W-1:0]       in_luma,
  input  wire logic [gsdp_pkg::PIX_W-1:0]       in_blue_chroma,
  input  wire logic [gsdp_pkg::PIX_W-1:0]       in_red_chroma,
  input  wire logic                             in_frame_end,
  // direction channel
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [gsdp_pkg::DIR_W-1:0]            out_direction
);
  import gsdp_pkg::*;

  gsdp_cfg_t   cfg_r;
  gsdp_cfg_t   cfg_nxt;
  logic        push_valid;
  logic        push_ready;
  gsdp_item_t  push_item;
  logic        pop_valid;
  logic        pop_ready;
  gsdp_item_t  pop_item;

  // register decode, writes beyond the list are ignored
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_LUMA_MIN:     cfg_nxt.luma_min     = cfg_data[PIX_W-1:0];
        CFG_LUMA_MAX:     cfg_nxt.luma_max     = cfg_data[PIX_W-1:0];
        CFG_CB_MIN:       cfg_nxt.cb_min       = cfg_data[PIX_W-1:0];
        CFG_CB_MAX:       cfg_nxt.cb_max       = cfg_data[PIX_W-1:0];
        CFG_CR_MIN:       cfg_nxt.cr_min       = cfg_data[PIX_W-1:0];
        CFG_CR_MAX:       cfg_nxt.cr_max       = cfg_data[PIX_W-1:0];
        CFG_FRAME_HEIGHT: cfg_nxt.frame_height = cfg_data[FH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.luma_min     <= '0;
      cfg_r.luma_max     <= '1;
      cfg_r.cb_min       <= '0;
      cfg_r.cb_max       <= '1;
      cfg_r.cr_min       <= '0;
      cfg_r.cr_max       <= '1;
      cfg_r.frame_height <= FH_W'(240);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // region test, colour test and sector sort
  gsdp_front #(
    .ROI_WIDTH       (ROI_WIDTH),
    .ROI_HALF_HEIGHT (ROI_HALF_HEIGHT)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_column      (in_column),
    .in_row         (in_row),
    .in_luma        (in_luma),
    .in_blue_chroma (in_blue_chroma),
    .in_red_chroma  (in_red_chroma),
    .in_frame_end   (in_frame_end),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_item      (push_item)
  );

  // decouples the sort pipeline from frame-end processing
  gsdp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // counters, divider, history and decision
  gsdp_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_item      (pop_item),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_direction (out_direction)
  );

endmodule

`default_nettype wire

>>> rtl/core/gsdp_front.sv
// ----------------------------------------------------------------------------
// gsdp_front
// Takes pixels, tests region and colour, squares the offsets and sorts
// each region pixel into its sector before it goes to the queue.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gsdp_front #(
  parameter int ROI_WIDTH       = 30,
  parameter int ROI_HALF_HEIGHT = 40
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire gsdp_pkg::gsdp_cfg_t         cfg,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [gsdp_pkg::COL_W-1:0]  in_column,
  input  wire logic [gsdp_pkg::ROW_W-1:0]  in_row,
  input  wire logic [gsdp_pkg::PIX_W-1:0]  in_luma,
  input  wire logic [gsdp_pkg::PIX_W-1:0]  in_blue_chroma,
  input  wire logic [gsdp_pkg::PIX_W-1:0]  in_red_chroma,
  input  wire logic                        in_frame_end,
  output logic                             push_valid,
  input  wire logic                        push_ready,
  output gsdp_pkg::gsdp_item_t             push_item
);
  import gsdp_pkg::*;

  // row math width, covers row plus half height
  localparam int RW = 12;

  logic [ROW_W-1:0]   mid;
  logic [RW-1:0]      row_ext;
  logic [RW-1:0]      mid_ext;
  logic [RW-1:0]      half_h;
  logic               in_region;
  logic               in_ground;
  logic signed [ROW_W:0] dy;
  logic [ROW_W:0]     dy_negated;
  logic [ROW_W-1:0]   dy_abs;
  logic [SQ_W-1:0]    xx_c;
  logic [SQ_W-1:0]    dysq_c;
  logic               in_fire;

  logic               s1_valid_r;
  logic               s1_valid_nxt;
  logic [SQ_W-1:0]    s1_xx_r;
  logic [SQ_W-1:0]    s1_dysq_r;
  logic               s1_dy_pos_r;
  logic               s1_dy_neg_r;
  logic               s1_col_zero_r;
  logic               s1_region_r;
  logic               s1_ground_r;
  logic               s1_last_r;
  logic               s1_need_push;
  logic               s1_leave;
  logic [TY_W-1:0]    ty;
  logic               below;
  logic [DIR_W-1:0]   sector;

  assign mid     = cfg.frame_height[FH_W-1:1];
  assign row_ext = RW'(in_row);
  assign mid_ext = RW'(mid);
  assign half_h  = RW'(ROI_HALF_HEIGHT);

  assign in_region = ({1'b0, in_column} < (COL_W + 1)'(ROI_WIDTH)) &&
                     (row_ext + half_h >= mid_ext) &&
                     (row_ext < mid_ext + half_h);

  assign in_ground = (in_luma >= cfg.luma_min) && (in_luma <= cfg.luma_max) &&
                     (in_blue_chroma >= cfg.cb_min) && (in_blue_chroma <= cfg.cb_max) &&
                     (in_red_chroma >= cfg.cr_min) && (in_red_chroma <= cfg.cr_max);

  assign dy         = $signed({1'b0, mid}) - $signed({1'b0, in_row});
  assign dy_negated = -dy;
  assign dy_abs     = dy[ROW_W] ? dy_negated[ROW_W-1:0] : dy[ROW_W-1:0];
  assign xx_c       = in_column * in_column;
  assign dysq_c     = dy_abs * dy_abs;

  // pixels outside the region that are not frame ends are dropped here
  assign s1_need_push = s1_region_r || s1_last_r;
  assign s1_leave     = s1_valid_r && (push_ready || !s1_need_push);
  assign in_stall     = s1_valid_r && !s1_leave;
  assign in_fire      = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_leave) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_xx_r       <= xx_c;
      s1_dysq_r     <= dysq_c;
      s1_dy_pos_r   <= !dy[ROW_W] && (dy != '0);
      s1_dy_neg_r   <= dy[ROW_W];
      s1_col_zero_r <= (in_column == '0);
      s1_region_r   <= in_region;
      s1_ground_r   <= in_ground;
      s1_last_r     <= in_frame_end;
    end
  end

  // x^2 against 3*dy^2
  assign ty    = TY_W'({s1_dysq_r, 1'b0}) + TY_W'(s1_dysq_r);
  assign below = TY_W'(s1_xx_r) < ty;

  always_comb begin
    if (s1_col_zero_r && !s1_dy_pos_r && !s1_dy_neg_r) begin
      sector = SECTOR_FIRST;
    end else if (s1_dy_pos_r && below) begin
      sector = SECTOR_FIRST;
    end else if (s1_dy_neg_r && below) begin
      sector = SECTOR_LAST;
    end else begin
      sector = SECTOR_MIDDLE;
    end
  end

  assign push_valid       = s1_valid_r && s1_need_push;
  assign push_item.region = s1_region_r;
  assign push_item.ground = s1_ground_r;
  assign push_item.sector = sector;
  assign push_item.last   = s1_last_r;

  `ASSERT_NEXT(a_front_capture, in_fire, s1_valid_r, "accepted item not held in stage")

endmodule

`default_nettype wire

>>> rtl/core/gsdp_queue.sv
// ----------------------------------------------------------------------------
// gsdp_queue
// Short queue of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gsdp_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push_valid,
  output logic                      push_ready,
  input  wire gsdp_pkg::gsdp_item_t push_item,
  output logic                      pop_valid,
  input  wire logic                 pop_ready,
  output gsdp_pkg::gsdp_item_t      pop_item
);
  import gsdp_pkg::*;

  gsdp_item_t               mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]   wr_ptr_r;
  logic [QUEUE_PTR_W-1:0]   wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0]   rd_ptr_r;
  logic [QUEUE_PTR_W-1:0]   rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0]   count_r;
  logic [QUEUE_CNT_W-1:0]   count_nxt;
  logic                     push_fire;
  logic                     pop_fire;
  logic                     push_only;

  assign push_ready = (count_r != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;
  assign push_only  = push_fire && !pop_fire;

  always_comb begin
    wr_ptr_nxt = push_fire ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop_fire ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push_fire && !pop_fire) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_fire && !push_fire) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  `ASSERT_CLK(a_queue_bound, count_r <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue count past depth")
  `ASSERT_NEXT(a_queue_grow, push_only, count_r == $past(count_r) + 1'b1, "queue did not grow")

endmodule

`default_nettype wire

>>> rtl/core/gsdp_back.sv
// ----------------------------------------------------------------------------
// gsdp_back
// Counts pixels per sector, and at frame end divides out percentages,
// rolls the history and picks the direction.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gsdp_back #(
  parameter int HISTORY_DEPTH = 3
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        pop_valid,
  output logic                             pop_ready,
  input  wire gsdp_pkg::gsdp_item_t        pop_item,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [gsdp_pkg::DIR_W-1:0]       out_direction
);
  import gsdp_pkg::*;

  localparam int SUM_W = $clog2(PERCENT_SCALE * HISTORY_DEPTH + 1);
  localparam logic [SUM_W-1:0] THRESH = SUM_W'(THRESHOLD_PERCENT * HISTORY_DEPTH);

  localparam logic [2:0] ST_COUNT  = 3'd0;
  localparam logic [2:0] ST_LOAD   = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_UPDATE = 3'd3;
  localparam logic [2:0] ST_DECIDE = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   ground_r [SECTORS];
  logic [CNT_W-1:0]   ground_nxt [SECTORS];
  logic [CNT_W-1:0]   region_r [SECTORS];
  logic [CNT_W-1:0]   region_nxt [SECTORS];
  logic [DIR_W-1:0]   sec_r, sec_nxt;
  logic [DIVD_W-1:0]  rem_r, rem_nxt;
  logic [DIVD_W-1:0]  div_r, div_nxt;
  logic [PCT_W-1:0]   quo_r, quo_nxt;
  logic [2:0]         step_r, step_nxt;
  logic [PCT_W-1:0]   pct_r [SECTORS];
  logic [PCT_W-1:0]   pct_nxt [SECTORS];
  logic [PCT_W-1:0]   hist_r [HISTORY_DEPTH][SECTORS];
  logic [PCT_W-1:0]   hist_nxt [HISTORY_DEPTH][SECTORS];
  logic [SUM_W-1:0]   sum_r [SECTORS];
  logic [SUM_W-1:0]   sum_nxt [SECTORS];
  logic               out_valid_r, out_valid_nxt;
  logic [DIR_W-1:0]   out_dir_r, out_dir_nxt;

  logic               pop_fire;
  logic [CNT_W-1:0]   sel_ground;
  logic [CNT_W-1:0]   sel_region;
  logic               ge;
  logic [DIR_W-1:0]   pick;
  logic               counts_ordered;
  logic               pct_in_range;

  assign pop_ready     = (state_r == ST_COUNT);
  assign pop_fire      = pop_valid && pop_ready;
  assign out_valid     = out_valid_r;
  assign out_direction = out_dir_r;

  // operand of the sector under division
  always_comb begin
    case (sec_r)
      SECTOR_FIRST: begin
        sel_ground = ground_r[0];
        sel_region = region_r[0];
      end
      SECTOR_MIDDLE: begin
        sel_ground = ground_r[1];
        sel_region = region_r[1];
      end
      default: begin
        sel_ground = ground_r[2];
        sel_region = region_r[2];
      end
    endcase
  end

  assign ge = (rem_r >= div_r);

  // middle wins at threshold or on a tie for the top, else the larger of first and last, first on a tie
  always_comb begin
    if ((sum_r[1] >= THRESH) || ((sum_r[1] >= sum_r[0]) && (sum_r[1] >= sum_r[2]))) begin
      pick = SECTOR_MIDDLE;
    end else if (sum_r[0] >= sum_r[2]) begin
      pick = SECTOR_FIRST;
    end else begin
      pick = SECTOR_LAST;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    sec_nxt       = sec_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    quo_nxt       = quo_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_dir_nxt   = out_dir_r;
    for (int k = 0; k < SECTORS; k++) begin
      ground_nxt[k] = ground_r[k];
      region_nxt[k] = region_r[k];
      pct_nxt[k]    = pct_r[k];
      sum_nxt[k]    = sum_r[k];
      for (int f = 0; f < HISTORY_DEPTH; f++) begin
        hist_nxt[f][k] = hist_r[f][k];
      end
    end

    case (state_r)
      ST_COUNT: begin
        if (pop_fire) begin
          for (int k = 0; k < SECTORS; k++) begin
            if (pop_item.region && (pop_item.sector == DIR_W'(k))) begin
              if (region_r[k] != COUNT_MAX) begin
                region_nxt[k] = region_r[k] + 1'b1;
              end
              if (pop_item.ground && (ground_r[k] != COUNT_MAX)) begin
                ground_nxt[k] = ground_r[k] + 1'b1;
              end
            end
          end
          if (pop_item.last) begin
            sec_nxt   = SECTOR_FIRST;
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        // ground * 100 as shifts, divisor aligned to the top quotient bit
        rem_nxt   = DIVD_W'({sel_ground, 6'b0}) + DIVD_W'({sel_ground, 5'b0}) +
                    DIVD_W'({sel_ground, 2'b0});
        div_nxt   = DIVD_W'({sel_region, 6'b0});
        quo_nxt   = '0;
        step_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        rem_nxt  = ge ? rem_r - div_r : rem_r;
        quo_nxt  = {quo_r[PCT_W-2:0], ge};
        div_nxt  = div_r >> 1;
        step_nxt = step_r + 1'b1;
        if (step_r == 3'(PCT_W - 1)) begin
          for (int k = 0; k < SECTORS; k++) begin
            if (sec_r == DIR_W'(k)) begin
              pct_nxt[k] = (sel_region == '0) ? '0 : {quo_r[PCT_W-2:0], ge};
            end
          end
          if (sec_r == SECTOR_LAST) begin
            state_nxt = ST_UPDATE;
          end else begin
            sec_nxt   = sec_r + 1'b1;
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_UPDATE: begin
        for (int k = 0; k < SECTORS; k++) begin
          sum_nxt[k] = sum_r[k] - SUM_W'(hist_r[HISTORY_DEPTH-1][k]) + SUM_W'(pct_r[k]);
          for (int f = HISTORY_DEPTH - 1; f > 0; f--) begin
            hist_nxt[f][k] = hist_r[f-1][k];
          end
          hist_nxt[0][k] = pct_r[k];
          ground_nxt[k]  = '0;
          region_nxt[k]  = '0;
        end
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_dir_nxt   = pick;
          state_nxt     = ST_COUNT;
        end
      end
      default: begin
        state_nxt = ST_COUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COUNT;
      out_valid_r <= 1'b0;
      for (int k = 0; k < SECTORS; k++) begin
        ground_r[k] <= '0;
        region_r[k] <= '0;
        sum_r[k]    <= '0;
        for (int f = 0; f < HISTORY_DEPTH; f++) begin
          hist_r[f][k] <= '0;
        end
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      for (int k = 0; k < SECTORS; k++) begin
        ground_r[k] <= ground_nxt[k];
        region_r[k] <= region_nxt[k];
        sum_r[k]    <= sum_nxt[k];
        for (int f = 0; f < HISTORY_DEPTH; f++) begin
          hist_r[f][k] <= hist_nxt[f][k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    sec_r     <= sec_nxt;
    rem_r     <= rem_nxt;
    div_r     <= div_nxt;
    quo_r     <= quo_nxt;
    step_r    <= step_nxt;
    out_dir_r <= out_dir_nxt;
    for (int k = 0; k < SECTORS; k++) begin
      pct_r[k] <= pct_nxt[k];
    end
  end

  // checker terms
  assign counts_ordered = (ground_r[0] <= region_r[0]) && (ground_r[1] <= region_r[1]) &&
                          (ground_r[2] <= region_r[2]);
  assign pct_in_range   = (pct_r[0] <= PCT_W'(PERCENT_SCALE)) &&
                          (pct_r[1] <= PCT_W'(PERCENT_SCALE)) &&
                          (pct_r[2] <= PCT_W'(PERCENT_SCALE));

  `ASSERT_CLK(a_back_ground_le_region, counts_ordered, "ground count above region count")
  `ASSERT_IMPL(a_back_pct_range, state_r == ST_UPDATE, pct_in_range, "percentage above 100")

endmodule

`default_nettype wire
